[src/u16u8_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared constants and the queue entry type passed from the front part of
// the encoder to the byte serialiser.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   // Largest output capacity the block will ever honour, in bytes.
   localparam int unsigned MAX_BUFFER_BYTES = 2048;

   // Capacity register width and reset value.
   localparam int unsigned CAP_W = 12;
   localparam logic [CAP_W-1:0] MAX_OUT_RESET = 12'd2048;

   // Depth of the queue between the front part and the serialiser.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Code unit boundaries.
   localparam logic [15:0] BOM_UNIT     = 16'hFEFF;
   localparam logic [15:0] HIGH_SUR_LO  = 16'hD800;
   localparam logic [15:0] HIGH_SUR_HI  = 16'hDBFF;
   localparam logic [15:0] LOW_SUR_BASE = 16'hDC00;
   localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;

   // Bytes reserved before a unit may be encoded: four data bytes at most.
   localparam logic [CAP_W:0] RESERVE_BYTES = 13'd4;

   // One queue entry: up to four data bytes, the count, and a terminator flag.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      n_data;
      logic            term;
   } u16u8_entry_type;

endpackage

[src/utf16_to_utf8_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one code unit per item with first and last
//   markers; an item is taken when req_valid is high and req_stall is low.
//   The response channel returns one byte per item; the last item of each
//   string is a zero terminator with rsp_end_of_string high.
//   csr_wr_en writes csr_wr_data into the output capacity register; write it
//   only while the block is idle.
//   A unit's bytes pass through the queue and then the result register.
//   Throughput is one result byte per cycle while the receiver does not
//   stall; a unit yields up to five bytes, a terminator included, and the
//   byte-wide result register sets this rate. A leading byte order mark, a
//   held high surrogate or a dropped unit yields no byte.
//   A two-entry queue parts the front from the serialiser: while the receiver
//   stalls, up to two further units are still taken, then req_stall rises.
//   Synchronous reset clears all string state and the queue, and sets the
//   capacity to 2048 bytes. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
   import u16u8_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [15:0]      req_code_unit,
   input  logic             req_first_unit,
   input  logic             req_last_unit,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_string,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   logic            accept;
   logic            push;
   u16u8_entry_type push_entry;
   logic            pop;
   logic            q_full;
   logic            head_valid;
   u16u8_entry_type head_entry;

   // Input side is held off only when the queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .code_unit   (req_code_unit),
      .first_unit  (req_first_unit),
      .last_unit   (req_last_unit),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .entry       (push_entry)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   u16u8_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule

[src/u16u8_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder front part
// Classifies each accepted code unit, keeps the per-string state and the
// capacity register, and forms the UTF-8 bytes for the queue.
// ----------------------------------------------------------------------------
module u16u8_front
   import u16u8_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [15:0]           code_unit,
   input  logic                  first_unit,
   input  logic                  last_unit,
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data,
   output logic                  push,
   output u16u8_entry_type       entry
);

   logic [CAP_W-1:0] max_out_ff, max_out_in;
   logic [15:0]      pend_high_ff, pend_high_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [CAP_W-1:0] bytes_ff, bytes_in;
   logic             stopped_ff, stopped_in;

   logic [CAP_W-1:0] cap;
   logic             eff_pend;
   logic [CAP_W-1:0] eff_bytes;
   logic             eff_stop;
   logic             cap_full;
   logic [31:0]      code_point;

   // Capacity in use is the smaller of the register and the buffer size.
   always_comb begin
      if (MAX_BUFFER_BYTES < 32'(max_out_ff)) begin
         cap = CAP_W'(MAX_BUFFER_BYTES);
      end else begin
         cap = max_out_ff;
      end
   end

   // A first unit starts from cleared string state.
   assign eff_pend  = first_unit ? 1'b0 : pend_valid_ff;
   assign eff_bytes = first_unit ? '0 : bytes_ff;
   assign eff_stop  = first_unit ? 1'b0 : stopped_ff;
   assign cap_full  = ({1'b0, eff_bytes} + RESERVE_BYTES) >= {1'b0, cap};

   // Supplementary code point, with wrapping arithmetic for a bad low unit.
   assign code_point = ((((32'(pend_high_ff) - 32'(HIGH_SUR_LO)) << 10)
                       | (32'(code_unit) - 32'(LOW_SUR_BASE))) + SUPP_BASE);

   // Classification and state update.
   always_comb begin
      max_out_in    = csr_wr_en ? csr_wr_data : max_out_ff;
      pend_high_in  = pend_high_ff;
      pend_valid_in = pend_valid_ff;
      bytes_in      = bytes_ff;
      stopped_in    = stopped_ff;
      entry         = '0;
      push          = 1'b0;
      if (accept) begin
         pend_high_in  = first_unit ? '0 : pend_high_ff;
         pend_valid_in = eff_pend;
         bytes_in      = eff_bytes;
         stopped_in    = eff_stop;
         if (eff_pend) begin
            // Held high surrogate joins with this unit into four bytes.
            entry.data[0] = code_point[25:18] | 8'hF0;
            entry.data[1] = {2'b10, code_point[17:12]};
            entry.data[2] = {2'b10, code_point[11:6]};
            entry.data[3] = {2'b10, code_point[5:0]};
            entry.n_data  = 3'd4;
            bytes_in      = eff_bytes + CAP_W'(4);
            pend_valid_in = 1'b0;
            pend_high_in  = '0;
         end else if (first_unit && (code_unit == BOM_UNIT)) begin
            // Leading byte order mark is dropped.
         end else if (eff_stop || cap_full) begin
            stopped_in = 1'b1;
         end else if (code_unit < ONE_BYTE_LIM) begin
            entry.data[0] = code_unit[7:0];
            entry.n_data  = 3'd1;
            bytes_in      = eff_bytes + CAP_W'(1);
         end else if (code_unit <= TWO_BYTE_MAX) begin
            entry.data[0] = {3'b110, code_unit[10:6]};
            entry.data[1] = {2'b10, code_unit[5:0]};
            entry.n_data  = 3'd2;
            bytes_in      = eff_bytes + CAP_W'(2);
         end else if ((code_unit inside {[HIGH_SUR_LO:HIGH_SUR_HI]}) && !last_unit) begin
            pend_high_in  = code_unit;
            pend_valid_in = 1'b1;
         end else begin
            entry.data[0] = {4'b1110, code_unit[15:12]};
            entry.data[1] = {2'b10, code_unit[11:6]};
            entry.data[2] = {2'b10, code_unit[5:0]};
            entry.n_data  = 3'd3;
            bytes_in      = eff_bytes + CAP_W'(3);
         end
         if (last_unit) begin
            entry.term    = 1'b1;
            pend_high_in  = '0;
            pend_valid_in = 1'b0;
            bytes_in      = '0;
            stopped_in    = 1'b0;
         end
         push = (entry.n_data != 3'd0) || entry.term;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff    <= MAX_OUT_RESET;
         pend_high_ff  <= '0;
         pend_valid_ff <= 1'b0;
         bytes_ff      <= '0;
         stopped_ff    <= 1'b0;
      end else begin
         max_out_ff    <= max_out_in;
         pend_high_ff  <= pend_high_in;
         pend_valid_ff <= pend_valid_in;
         bytes_ff      <= bytes_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

[src/u16u8_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder queue
// Short first-in first-out queue of byte groups between the front part and
// the serialiser.
// ----------------------------------------------------------------------------
module u16u8_queue
   import u16u8_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  u16u8_entry_type push_entry,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output u16u8_entry_type head_entry
);

   u16u8_entry_type   mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("item popped from an empty queue");
`endif

endmodule

[src/u16u8_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder serialiser
// Sends queued byte groups one byte per cycle, unless the receiver stalls,
// through a registered result stage, with the terminator after the data bytes.
// ----------------------------------------------------------------------------
module u16u8_back
   import u16u8_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  u16u8_entry_type head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_end_of_string
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       eos_ff, eos_in;

   logic       load;
   logic       is_data;
   logic [2:0] total;

   assign total   = head_entry.n_data + 3'(head_entry.term);
   assign is_data = idx_ff < head_entry.n_data;
   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign pop     = load && (idx_ff == total - 3'd1);

   // Next byte selection and result register control.
   always_comb begin
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      eos_in   = eos_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = is_data ? head_entry.data[idx_ff[1:0]] : 8'h00;
         eos_in   = !is_data;
         idx_in   = pop ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_string = eos_ff;

endmodule

[verif/utf16_to_utf8_encoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder checker
// Watches the code unit and byte channels of the encoder and keeps its own
// model of the string state and the capacity register. It works out the UTF-8
// bytes of every accepted code unit and compares each accepted byte with the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_checker
   import u16u8_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [15:0]      req_code_unit,
   input  logic             req_first_unit,
   input  logic             req_last_unit,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [7:0]       rsp_out_byte,
   input  logic             rsp_end_of_string,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output int unsigned      bytes_outstanding,
   output int unsigned      mismatch_count,
   output int unsigned      bytes_compared,
   output int unsigned      strings_ended
);

   // UTF-8 lead and continuation prefixes.
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } utf8_byte_type;

   // Bytes still awaited on the result channel, oldest first.
   utf8_byte_type utf8_bytes_q[$];
   utf8_byte_type expected_byte;

   // Model of the capacity register and of the per-string state.
   logic [CAP_W-1:0] capacity;
   logic [15:0]      held_high;
   logic             held_valid;
   logic [11:0]      out_count;
   logic             stopped;

   int unsigned fail_total     = 0;
   int unsigned compared_total = 0;
   int unsigned ended_total    = 0;

   function automatic void clear_string();
      held_high  = '0;
      held_valid = 1'b0;
      out_count  = '0;
      stopped    = 1'b0;
   endfunction

   function automatic void push_byte(input logic [7:0] data, input logic eos);
      utf8_byte_type entry;
      entry.data = data;
      entry.eos  = eos;
      utf8_bytes_q.push_back(entry);
   endfunction

   // Works out the bytes that one code unit yields and updates the state.
   function automatic void encode_unit(input logic [15:0] unit, input logic is_first,
                                       input logic is_last);
      logic [31:0] code_point;
      int unsigned limit;
      int unsigned used;
      limit = (capacity > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : int'(capacity);
      if (is_first) begin
         clear_string();
      end
      used = out_count;
      if (held_valid) begin
         // The unit after a held high surrogate always completes the pair.
         code_point = (((32'(held_high) - 32'(HIGH_SUR_LO)) << 10) |
                       (32'(unit) - 32'(LOW_SUR_BASE))) + SUPP_BASE;
         push_byte(code_point[25:18] | LEAD_FOUR, 1'b0);
         push_byte({2'b00, code_point[17:12]} | CONT_MARK, 1'b0);
         push_byte({2'b00, code_point[11:6]} | CONT_MARK, 1'b0);
         push_byte({2'b00, code_point[5:0]} | CONT_MARK, 1'b0);
         out_count  = out_count + 12'd4;
         held_valid = 1'b0;
         held_high  = '0;
      end else if (is_first && unit == BOM_UNIT) begin
         // A leading byte order mark yields nothing.
      end else if (stopped || used + 4 >= limit) begin
         stopped = 1'b1;
      end else if (unit < ONE_BYTE_LIM) begin
         push_byte(unit[7:0], 1'b0);
         out_count = out_count + 12'd1;
      end else if (unit <= TWO_BYTE_MAX) begin
         push_byte({3'b000, unit[10:6]} | LEAD_TWO, 1'b0);
         push_byte({2'b00, unit[5:0]} | CONT_MARK, 1'b0);
         out_count = out_count + 12'd2;
      end else if (unit >= HIGH_SUR_LO && unit <= HIGH_SUR_HI && !is_last) begin
         held_high  = unit;
         held_valid = 1'b1;
      end else begin
         push_byte({4'b0000, unit[15:12]} | LEAD_THREE, 1'b0);
         push_byte({2'b00, unit[11:6]} | CONT_MARK, 1'b0);
         push_byte({2'b00, unit[5:0]} | CONT_MARK, 1'b0);
         out_count = out_count + 12'd3;
      end
      if (is_last) begin
         push_byte(8'h00, 1'b1);
         clear_string();
      end
   endfunction

   // Compare results first, so a byte can never match a unit taken at the
   // same edge, then follow register writes and new code units.
   always @(posedge clock) begin
      if (reset) begin
         capacity = MAX_OUT_RESET;
         clear_string();
         utf8_bytes_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (utf8_bytes_q.size() == 0) begin
               $display("%0t: byte %02h with end flag %0b arrived, none expected",
                        $time, rsp_out_byte, rsp_end_of_string);
               fail_total++;
            end else begin
               expected_byte = utf8_bytes_q.pop_front();
               compared_total++;
               if (expected_byte.eos) begin
                  ended_total++;
               end
               if (rsp_out_byte !== expected_byte.data) begin
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, expected_byte.data, rsp_out_byte);
                  fail_total++;
               end
               if (rsp_end_of_string !== expected_byte.eos) begin
                  $display("%0t: end_of_string mismatch, expected %0b, actual %0b",
                           $time, expected_byte.eos, rsp_end_of_string);
                  fail_total++;
               end
            end
         end
         if (csr_wr_en === 1'b1) begin
            capacity = csr_wr_data;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            encode_unit(req_code_unit, req_first_unit, req_last_unit);
         end
      end
      bytes_outstanding <= utf8_bytes_q.size();
      mismatch_count    <= fail_total;
      bytes_compared    <= compared_total;
      strings_ended     <= ended_total;
   end

endmodule

[verif/utf16_to_utf8_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder testbench
// Drives directed code units covering every encoding length, byte order marks,
// surrogate pairs and broken strings, then random strings under several
// output capacities and idle patterns. A checker beside the block predicts and
// compares the byte stream; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_tb;
   import u16u8_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 3;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 120;
   localparam int CHUNK_UNITS   = 36;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic [15:0]      req_code_unit  = '0;
   logic             req_first_unit = 1'b0;
   logic             req_last_unit  = 1'b0;
   logic             rsp_stall      = 1'b0;
   logic             csr_wr_en      = 1'b0;
   logic [CAP_W-1:0] csr_wr_data    = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic [7:0]       rsp_out_byte;
   logic             rsp_end_of_string;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned compared;
   int unsigned ended;

   int unsigned tx_idle_pct    = 0;
   int unsigned rx_idle_pct    = 0;
   int unsigned hold_trigger   = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;
   int unsigned units_sent     = 0;
   int unsigned directed_units = 0;
   int unsigned cycle_count    = 0;
   int unsigned chunk_target;

   // Capacity per random chunk; pairs of chunks share one idle pattern.
   logic [CAP_W-1:0] capacity_plan [6] = '{12'd4095, 12'd5, 12'd3, 12'd40, 12'd2048, 12'd0};
   int unsigned      tx_plan [3]       = '{35, 50, 0};
   int unsigned      rx_plan [3]       = '{50, 35, 0};

   always #(CLK_PERIOD / 2) clock = ~clock;

   utf16_to_utf8_encoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_first_unit    (req_first_unit),
      .req_last_unit     (req_last_unit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   utf16_to_utf8_encoder_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_first_unit    (req_first_unit),
      .req_last_unit     (req_last_unit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .bytes_outstanding (outstanding),
      .mismatch_count    (mismatches),
      .bytes_compared    (compared),
      .strings_ended     (ended)
   );

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d bytes awaited.", cycle_count, outstanding);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offers one code unit, idling at random first, and waits until it is taken.
   task automatic send_unit(input logic [15:0] code, input logic is_first, input logic is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_code_unit  <= code;
      req_first_unit <= is_first;
      req_last_unit  <= is_last;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      units_sent++;
   endtask

   // Stops offering items and waits until every awaited byte has come, then
   // waits out the settle time for units that yield no byte.
   task automatic drain_outstanding();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_outstanding();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed strings of mixed characters; now and then a string
   // without its first or last marker, or a raw 16-bit unit.
   task automatic send_random_string();
      logic [15:0] units[$];
      int unsigned length;
      bit          no_first;
      bit          no_last;
      length   = $urandom_range(10, 1);
      no_first = ($urandom_range(15) == 0);
      no_last  = ($urandom_range(15) == 0);
      if ($urandom_range(7) == 0) begin
         units.push_back(BOM_UNIT);
      end
      repeat (length) begin
         case ($urandom_range(9))
            0, 1, 2: units.push_back(16'($urandom_range(16'h007F)));
            3, 4:    units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
            5, 6:    units.push_back(16'($urandom_range(16'hFFFF, 16'h0800)));
            7, 8: begin
               units.push_back(16'($urandom_range(HIGH_SUR_HI, HIGH_SUR_LO)));
               units.push_back(16'($urandom_range(16'hDFFF, LOW_SUR_BASE)));
            end
            default: units.push_back(16'($urandom));
         endcase
      end
      foreach (units[k]) begin
         send_unit(units[k], k == 0 && !no_first, k == units.size() - 1 && !no_last);
      end
   endtask

   initial begin
      tx_idle_pct = tx_plan[0];
      rx_idle_pct <= rx_plan[0];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity: field extremes and each length.
      send_unit(16'h0000, 1'b1, 1'b1);
      send_unit(16'h007F, 1'b1, 1'b0);
      send_unit(ONE_BYTE_LIM, 1'b0, 1'b0);
      send_unit(TWO_BYTE_MAX, 1'b0, 1'b0);
      send_unit(16'h0800, 1'b0, 1'b0);
      send_unit(16'hFFFF, 1'b0, 1'b1);
      // Leading byte order mark is skipped, also when it is the whole string.
      send_unit(BOM_UNIT, 1'b1, 1'b0);
      send_unit(16'h0041, 1'b0, 1'b1);
      send_unit(BOM_UNIT, 1'b1, 1'b1);
      // A byte order mark later in the string is an ordinary unit.
      send_unit(16'h0041, 1'b1, 1'b0);
      send_unit(BOM_UNIT, 1'b0, 1'b1);
      // Surrogate pairs at both ends of the range.
      send_unit(HIGH_SUR_LO, 1'b1, 1'b0);
      send_unit(LOW_SUR_BASE, 1'b0, 1'b1);
      send_unit(HIGH_SUR_HI, 1'b1, 1'b0);
      send_unit(16'hDFFF, 1'b0, 1'b1);
      // A high surrogate as the last unit is encoded on its own.
      send_unit(HIGH_SUR_HI, 1'b1, 1'b1);
      // The unit after a held high surrogate is joined whatever its value.
      send_unit(16'hD83D, 1'b1, 1'b0);
      send_unit(16'h0041, 1'b0, 1'b1);
      // A lone low surrogate gives three bytes.
      send_unit(LOW_SUR_BASE, 1'b1, 1'b1);
      // A held surrogate of an unterminated string is dropped by a new start.
      send_unit(HIGH_SUR_LO, 1'b1, 1'b0);
      send_unit(16'h0042, 1'b1, 1'b1);
      // After a string end, a unit without a start marker opens a fresh one.
      send_unit(BOM_UNIT, 1'b0, 1'b1);
      directed_units = units_sent;

      // Random strings in chunks, each under its own capacity setting.
      foreach (capacity_plan[p]) begin
         if (p % 2 == 0) begin
            tx_idle_pct = tx_plan[p / 2];
            rx_idle_pct <= rx_plan[p / 2];
         end
         write_capacity(capacity_plan[p]);
         // Long receiver hold-off while the sender keeps offering units.
         if (p == 4) begin
            hold_trigger <= hold_trigger + 1;
         end
         chunk_target = units_sent + CHUNK_UNITS;
         while (units_sent < chunk_target) begin
            send_random_string();
         end
      end
      drain_outstanding();

      $display("Sent %0d code units, %0d of them directed, under capacities 0 to 4095.",
               units_sent, directed_units);
      $display("Compared %0d bytes over %0d terminated strings.", compared, ended);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
